// ===== design/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Shared types, field widths and default sizes for the slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

   localparam int SLOT_COUNT_DEFAULT = 256;
   localparam int GEN_BITS_DEFAULT   = 16;
   localparam int SPACE_BITS_DEFAULT = 8;

   localparam int MODE_W   = 2;
   localparam int SPACE_W  = 8;
   localparam int INDEX_W  = 8;
   localparam int HGEN_W   = 16;
   localparam int STATUS_W = 2;
   localparam int FREED_W  = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_UNLOAD  = 2'd2,
      MODE_CHECK   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_STALE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [SPACE_W-1:0] space_id;
      logic [INDEX_W-1:0] slot_index;
      logic [HGEN_W-1:0]  handle_generation;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] result_index;
      logic [HGEN_W-1:0]  result_generation;
      status_type         status;
      logic [FREED_W-1:0] freed_count;
   } rsp_type;

   typedef struct packed {
      logic handle_ok;
      logic space_hit;
   } verdict_type;

endpackage

// ===== design/gsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gsa_judge.sv =====
// ----------------------------------------------------------------------------
// Slot entry judge
// Shared compare and increment unit that evaluates one fetched slot entry.
// ----------------------------------------------------------------------------
module gsa_judge
   import gsa_pkg::*;
#(
   parameter int GEN_BITS   = GEN_BITS_DEFAULT,
   parameter int SPACE_BITS = SPACE_BITS_DEFAULT
) (
   input  logic                  entry_alive,
   input  logic [SPACE_BITS-1:0] entry_space,
   input  logic [GEN_BITS-1:0]   entry_gen,
   input  logic [SPACE_BITS-1:0] want_space,
   input  logic [HGEN_W-1:0]     want_gen,
   output verdict_type           verdict,
   output logic [GEN_BITS-1:0]   next_gen
);

   localparam int CMP_W = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

   logic gen_match;

   assign gen_match         = (CMP_W'(entry_gen) == CMP_W'(want_gen));
   assign verdict.handle_ok = entry_alive && gen_match;
   assign verdict.space_hit = entry_alive && (entry_space == want_space);
   assign next_gen          = entry_gen + GEN_BITS'(1);

endmodule

// ===== design/generational_slot_allocator.sv =====
// Allocate of a never-used slot, a full table and an out-of-range handle: answered from idle.
// Release, check: idle then apply; recycled-slot allocate: idle, pop (free stack), apply (slot).
// Unload space: the scan state reads every slot handed out, one slot read per cycle.
// Throughput: one transaction at a time; the next is accepted once busy falls, at the earliest
// in the cycle the previous result is shown on rsp_strobe; the receiver cannot stall it.
// Reset clears state, counters and flags; slots and stack entries are never read before written.
// ----------------------------------------------------------------------------
// Generational slot allocator
// Handle table with generation counters, a LIFO free stack and space unload.
// ----------------------------------------------------------------------------
module generational_slot_allocator
   import gsa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   parameter int GEN_BITS   = GEN_BITS_DEFAULT,
   parameter int SPACE_BITS = SPACE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W = 1 + SPACE_BITS + GEN_BITS;
   localparam int IXW     = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int CW      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int GW      = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
   localparam int SW      = (SPACE_BITS > SPACE_W) ? SPACE_BITS : SPACE_W;
   localparam int FW      = (CNT_W > FREED_W) ? CNT_W : FREED_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_APPLY,
      ST_SCAN
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0] freed_ff, freed_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic               slot_we;
   logic [IDX_W-1:0]   slot_waddr;
   logic [ENTRY_W-1:0] slot_wdata;
   logic [IDX_W-1:0]   slot_raddr;
   logic [ENTRY_W-1:0] slot_rdata;
   logic               stack_we;
   logic [IDX_W-1:0]   stack_waddr;
   logic [IDX_W-1:0]   stack_wdata;
   logic [IDX_W-1:0]   stack_raddr;
   logic [IDX_W-1:0]   stack_rdata;

   logic                  entry_alive;
   logic [SPACE_BITS-1:0] entry_space;
   logic [GEN_BITS-1:0]   entry_gen;
   logic [GEN_BITS-1:0]   next_gen;
   verdict_type           verdict;
   logic [SW-1:0]         space_now_wide;
   logic [SW-1:0]         space_held_wide;
   logic [SPACE_BITS-1:0] space_now;
   logic [SPACE_BITS-1:0] space_held;
   logic [GW-1:0]         entry_gen_wide;
   logic [IXW-1:0]        addr_wide;
   logic [IXW-1:0]        used_wide;
   logic [FW-1:0]         freed_wide;
   logic                  accept;
   logic                  in_range;

   assign accept          = start && !busy;
   assign busy            = (state_ff != ST_IDLE);
   assign space_now_wide  = SW'(req_data.space_id);
   assign space_held_wide = SW'(req_ff.space_id);
   assign space_now       = space_now_wide[SPACE_BITS-1:0];
   assign space_held      = space_held_wide[SPACE_BITS-1:0];
   assign {entry_alive, entry_space, entry_gen} = slot_rdata;
   assign entry_gen_wide  = GW'(entry_gen);
   assign addr_wide       = IXW'(addr_ff);
   assign used_wide       = IXW'(used_ff);
   assign freed_wide      = FW'(freed_ff);
   assign in_range        = (CW'(req_data.slot_index) < CW'(used_ff));

   gsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   gsa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOT_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   gsa_judge #(
      .GEN_BITS   (GEN_BITS),
      .SPACE_BITS (SPACE_BITS)
   ) u_judge (
      .entry_alive (entry_alive),
      .entry_space (entry_space),
      .entry_gen   (entry_gen),
      .want_space  (space_held),
      .want_gen    (req_ff.handle_generation),
      .verdict     (verdict),
      .next_gen    (next_gen)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      free_cnt_in  = free_cnt_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      freed_in     = freed_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      slot_we      = 1'b0;
      slot_waddr   = addr_ff;
      slot_wdata   = {1'b0, entry_space, next_gen};
      slot_raddr   = addr_ff;
      stack_we     = 1'b0;
      stack_waddr  = free_cnt_ff[IDX_W-1:0];
      stack_wdata  = addr_ff;
      stack_raddr  = IDX_W'(free_cnt_ff - CNT_W'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in                        = req_data;
               rsp_in.result_index           = req_data.slot_index;
               rsp_in.result_generation      = '0;
               rsp_in.status                 = STATUS_OK;
               rsp_in.freed_count            = '0;
               case (req_data.mode)
                  MODE_ALLOC: begin
                     if (free_cnt_ff != '0) begin
                        free_cnt_in = free_cnt_ff - CNT_W'(1);
                        state_in    = ST_POP;
                     end else if (used_ff < CNT_W'(SLOT_COUNT)) begin
                        slot_we             = 1'b1;
                        slot_waddr          = used_ff[IDX_W-1:0];
                        slot_wdata          = {1'b1, space_now, GEN_BITS'(0)};
                        used_in             = used_ff + CNT_W'(1);
                        rsp_in.result_index = used_wide[INDEX_W-1:0];
                        strobe_in           = 1'b1;
                     end else begin
                        rsp_in.result_index = '0;
                        rsp_in.status       = STATUS_FULL;
                        strobe_in           = 1'b1;
                     end
                  end
                  MODE_RELEASE, MODE_CHECK: begin
                     if (in_range) begin
                        addr_in    = IDX_W'(req_data.slot_index);
                        slot_raddr = IDX_W'(req_data.slot_index);
                        state_in   = ST_APPLY;
                     end else begin
                        rsp_in.status = STATUS_STALE;
                        strobe_in     = 1'b1;
                     end
                  end
                  MODE_UNLOAD: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     freed_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            addr_in    = stack_rdata;
            slot_raddr = stack_rdata;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            case (req_ff.mode)
               MODE_ALLOC: begin
                  slot_we                  = 1'b1;
                  slot_wdata               = {1'b1, space_held, entry_gen};
                  rsp_in.result_index      = addr_wide[INDEX_W-1:0];
                  rsp_in.result_generation = entry_gen_wide[HGEN_W-1:0];
               end
               MODE_RELEASE: begin
                  if (verdict.handle_ok) begin
                     slot_we = 1'b1;
                     if (free_cnt_ff < CNT_W'(SLOT_COUNT)) begin
                        stack_we    = 1'b1;
                        free_cnt_in = free_cnt_ff + CNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = STATUS_STALE;
                  end
               end
               MODE_CHECK: begin
                  rsp_in.result_generation = entry_gen_wide[HGEN_W-1:0];
                  if (!verdict.handle_ok) begin
                     rsp_in.status = STATUS_STALE;
                  end
               end
               default: begin
                  rsp_in.status = STATUS_OK;
               end
            endcase
         end
         ST_SCAN: begin
            if (pend_ff && verdict.space_hit) begin
               slot_we     = 1'b1;
               slot_waddr  = pend_addr_ff;
               stack_wdata = pend_addr_ff;
               freed_in    = freed_ff + CNT_W'(1);
               if (free_cnt_ff < CNT_W'(SLOT_COUNT)) begin
                  stack_we    = 1'b1;
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end
            if (scan_ff < used_ff) begin
               slot_raddr   = scan_ff[IDX_W-1:0];
               pend_addr_in = scan_ff[IDX_W-1:0];
               pend_in      = 1'b1;
               scan_in      = scan_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_in.freed_count = freed_wide[FREED_W-1:0];
                  strobe_in          = 1'b1;
                  state_in           = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         free_cnt_ff <= '0;
         used_ff     <= '0;
         pend_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
         used_ff     <= used_in;
         pend_ff     <= pend_in;
         strobe_ff   <= strobe_in;
      end
      req_ff       <= req_in;
      addr_ff      <= addr_in;
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      freed_ff     <= freed_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result strobe raised while a transaction is still in progress.");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= used_ff)
      else $error("Free stack holds more entries than slots handed out.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("Accepted transaction neither started nor completed.");

   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (used_ff >= $past(used_ff)))
      else $error("Count of slots handed out decreased.");

   a_scan_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_strobe)
      else $error("Result strobe raised during a space unload scan.");

endmodule

// ===== bench/generational_slot_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives a short scripted sequence, a short allocate and release run on one
// slot and weighted random transactions, and checks every result against its
// typed row or a predictor of generations, alive bits, spaces and free stack.
// ----------------------------------------------------------------------------
module generational_slot_allocator_tb;
   import gsa_pkg::*;

   localparam int SLOTS          = SLOT_COUNT_DEFAULT;
   localparam int RANDOM_ITEMS   = 750;
   localparam int FILL_END       = 350;
   localparam int DRAIN_END      = 550;
   localparam int CALM_START     = 620;
   localparam int REUSE_PAIRS    = 40;
   localparam int SETTLE_CYCLES  = SLOTS + 40;
   localparam int TIMEOUT_NS     = 20_000_000;
   localparam int SCRIPT_ROWS    = 20;

   localparam logic [3:0][SPACE_W-1:0] SPACE_POOL = {8'hA5, 8'h5A, 8'hFF, 8'h00};
   localparam rsp_type NO_RSP = '{8'h00, 16'h0000, STATUS_OK, 9'd0};

   typedef struct packed {
      req_type op;
      logic    typed;
      rsp_type typed_rsp;
   } script_row_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic [HGEN_W-1:0]  gen_table     [SLOTS] = '{default: '0};
   logic               alive_table   [SLOTS] = '{default: 1'b0};
   logic [SPACE_W-1:0] owner_space   [SLOTS] = '{default: '0};
   logic [INDEX_W-1:0] recycle_stack [SLOTS] = '{default: '0};
   int                 recycle_depth = 0;
   int                 high_water    = 0;

   rsp_type pending_results [$];
   int      mismatch_count = 0;

   script_row_type directed_script [SCRIPT_ROWS] = '{
      '{'{MODE_CHECK,   8'h00, 8'h00, 16'h0000}, 1'b1, '{8'h00, 16'h0000, STATUS_STALE, 9'd0}},
      '{'{MODE_RELEASE, 8'h00, 8'h05, 16'h0000}, 1'b1, '{8'h05, 16'h0000, STATUS_STALE, 9'd0}},
      '{'{MODE_ALLOC,   8'h00, 8'hFF, 16'hFFFF}, 1'b1, '{8'h00, 16'h0000, STATUS_OK,    9'd0}},
      '{'{MODE_ALLOC,   8'hFF, 8'h00, 16'h0000}, 1'b1, '{8'h01, 16'h0000, STATUS_OK,    9'd0}},
      '{'{MODE_ALLOC,   8'h55, 8'hAA, 16'hAAAA}, 1'b1, '{8'h02, 16'h0000, STATUS_OK,    9'd0}},
      '{'{MODE_CHECK,   8'h00, 8'h01, 16'h0000}, 1'b1, '{8'h01, 16'h0000, STATUS_OK,    9'd0}},
      '{'{MODE_CHECK,   8'h00, 8'h01, 16'hFFFF}, 1'b1, '{8'h01, 16'h0000, STATUS_STALE, 9'd0}},
      '{'{MODE_RELEASE, 8'h00, 8'h01, 16'hFFFF}, 1'b1, '{8'h01, 16'h0000, STATUS_STALE, 9'd0}},
      '{'{MODE_RELEASE, 8'h00, 8'h01, 16'h0000}, 1'b1, '{8'h01, 16'h0000, STATUS_OK,    9'd0}},
      '{'{MODE_RELEASE, 8'h00, 8'h01, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_CHECK,   8'h00, 8'h01, 16'h0001}, 1'b0, NO_RSP},
      '{'{MODE_ALLOC,   8'hAA, 8'h00, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_UNLOAD,  8'hFF, 8'hFF, 16'h5555}, 1'b0, NO_RSP},
      '{'{MODE_UNLOAD,  8'h00, 8'h3C, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_UNLOAD,  8'hAA, 8'hC3, 16'hFFFF}, 1'b0, NO_RSP},
      '{'{MODE_ALLOC,   8'h55, 8'h00, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_ALLOC,   8'h55, 8'h00, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_UNLOAD,  8'h55, 8'h00, 16'h0000}, 1'b0, NO_RSP},
      '{'{MODE_CHECK,   8'h00, 8'hFF, 16'hFFFF}, 1'b1, '{8'hFF, 16'h0000, STATUS_STALE, 9'd0}},
      '{'{MODE_UNLOAD,  8'h55, 8'h7E, 16'h8001}, 1'b0, NO_RSP}
   };

   generational_slot_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void retire_slot(int idx);
      gen_table[idx]   = gen_table[idx] + 1'b1;
      alive_table[idx] = 1'b0;
      if (recycle_depth < SLOTS) begin
         recycle_stack[recycle_depth] = INDEX_W'(idx);
         recycle_depth++;
      end
   endfunction

   function automatic rsp_type apply_table_op(req_type op);
      rsp_type res;
      int      slot;
      int      freed;
      int      sidx;
      res  = '{op.slot_index, 16'h0000, STATUS_OK, 9'd0};
      sidx = int'(op.slot_index);
      case (op.mode)
         MODE_ALLOC: begin
            slot = -1;
            if (recycle_depth > 0) begin
               recycle_depth--;
               slot = int'(recycle_stack[recycle_depth]);
            end else if (high_water < SLOTS) begin
               slot = high_water;
               high_water++;
            end
            if (slot >= 0) begin
               alive_table[slot]     = 1'b1;
               owner_space[slot]     = op.space_id;
               res.result_index      = INDEX_W'(slot);
               res.result_generation = gen_table[slot];
            end else begin
               res.result_index = '0;
               res.status       = STATUS_FULL;
            end
         end
         MODE_RELEASE: begin
            if (sidx >= high_water || gen_table[sidx] != op.handle_generation
                || !alive_table[sidx]) begin
               res.status = STATUS_STALE;
            end else begin
               retire_slot(sidx);
            end
         end
         MODE_UNLOAD: begin
            freed = 0;
            for (int i = 0; i < high_water; i++) begin
               if (alive_table[i] && owner_space[i] == op.space_id) begin
                  retire_slot(i);
                  freed++;
               end
            end
            res.freed_count = FREED_W'(freed);
         end
         default: begin
            if (sidx >= high_water) begin
               res.status = STATUS_STALE;
            end else begin
               res.result_generation = gen_table[sidx];
               if (gen_table[sidx] != op.handle_generation
                   || !alive_table[sidx]) begin
                  res.status = STATUS_STALE;
               end
            end
         end
      endcase
      return res;
   endfunction

   task automatic send_op(input req_type op, input logic typed, input rsp_type typed_rsp,
                          output rsp_type predicted);
      req_data <= op;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = apply_table_op(op);
      pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            check_field("result_index", 32'(want.result_index),
                        32'(rsp_data.result_index));
            check_field("result_generation", 32'(want.result_generation),
                        32'(rsp_data.result_generation));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("freed_count", 32'(want.freed_count),
                        32'(rsp_data.freed_count));
         end
      end
   end

   initial begin
      req_type op;
      rsp_type got;
      int      idx;
      int      w;
      int      a;
      int      b;
      int      c;
      int      sel;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         send_op(directed_script[i].op, directed_script[i].typed,
                 directed_script[i].typed_rsp, got);
      end

      for (int p = 0; p < REUSE_PAIRS; p++) begin
         op = '{MODE_ALLOC, 8'h77, 8'h00, 16'h0000};
         send_op(op, 1'b0, NO_RSP, got);
         op = '{MODE_RELEASE, 8'h00, got.result_index, got.result_generation};
         send_op(op, 1'b0, NO_RSP, got);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < FILL_END) begin
            a = 85; b = 90; c = 98;
         end else if (n < DRAIN_END) begin
            a = 15; b = 55; c = 75;
         end else begin
            a = 35; b = 60; c = 85;
         end
         w = $urandom_range(0, 99);
         op.mode = (w < a) ? MODE_ALLOC : (w < b) ? MODE_RELEASE :
                   (w < c) ? MODE_CHECK : MODE_UNLOAD;
         op.slot_index        = INDEX_W'($urandom_range(0, 255));
         op.handle_generation = HGEN_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 99) < 80 && !(op.mode == MODE_UNLOAD && n < FILL_END)) begin
            op.space_id = SPACE_POOL[$urandom_range(0, 3)];
         end else begin
            op.space_id = SPACE_W'($urandom_range(0, 255));
         end
         sel = $urandom_range(0, 99);
         if ((op.mode == MODE_RELEASE || op.mode == MODE_CHECK) && sel < 70 && high_water > 0)
         begin
            idx = 0;
            for (int k = 0; k < 8; k++) begin
               idx = $urandom_range(0, high_water - 1);
               if (alive_table[idx]) break;
            end
            op.slot_index        = INDEX_W'(idx);
            op.handle_generation = gen_table[idx];
            if (sel >= 55) begin
               op.handle_generation = gen_table[idx] ^ (16'h0001 << $urandom_range(0, 15));
            end
         end
         send_op(op, 1'b0, NO_RSP, got);
         if (n < CALM_START && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
